// ----- rtl/core/bpc_pkg.sv -----
package bpc_pkg;

	// input item kinds / result kinds
	typedef enum logic {
		MODE_TEMP  = 1'b0,
		MODE_PRESS = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_NO_TEMP  = 2'd2
	} err_t;

	// register indexes, byte address = 8 * index
	typedef enum logic [1:0] {
		REG_CAL_A = 2'd0,
		REG_CAL_B = 2'd1,
		REG_CAL_C = 2'd2,
		REG_OSS   = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_MUL,
		ST_T_X1,
		ST_T_DEN,
		ST_T_DIV,
		ST_P_B6,
		ST_P_M_SQH,
		ST_P_M_SQL,
		ST_P_SQ,
		ST_P_M_X1,
		ST_P_M_X2,
		ST_P_M_X1B,
		ST_P_M_X2B,
		ST_P_X3,
		ST_P_M_B4,
		ST_P_M_B7,
		ST_P_B7,
		ST_P_DIV,
		ST_P_M_PH,
		ST_P_M_PL,
		ST_P_PSQ,
		ST_P_M_C1,
		ST_P_M_C2,
		ST_P_FIN,
		ST_DONE
	} state_t;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	localparam logic signed [63:0] B6_OFFSET  = 64'sd4000;
	localparam logic        [31:0] B4_OFFSET  = 32'd32768;
	localparam logic        [15:0] B7_SCALE   = 16'd50000;
	localparam logic signed [17:0] P_COEF_SQ  = 18'sd3038;
	localparam logic signed [17:0] P_COEF_LIN = -18'sd7357;
	localparam logic signed [63:0] P_OFFSET   = 64'sd3791;

endpackage

// ----- rtl/core/barometric_pressure_compensation.sv -----
// Barometric pressure compensation.
// Calibration words and the oversampling setting are written over the APB
// port (64-bit data, register i at byte 8*i); the user must write them only
// while the block is idle, which the block itself does not enforce.
// Input beats on s_axis: tuser is the kind (0 raw temperature, 1 raw
// pressure), tdata[18:0] the raw reading. One result beat per input beat on
// m_axis: tdata is the value (tenths of a degree C or pascals), tuser holds
// the kind and the error code.
// Results are paced by the radix-2 divider and the single 52x18 multiplier
// that every product goes through, one a cycle. A pressure beat without a
// valid stored temperature term goes straight to done with an error.
// One item is worked at a time: s_axis_tready is high only in the idle
// state. The result goes into an output register, so the next beat is taken
// while a result is still waiting; if the receiver stalls and a second
// result is done, the sequencer holds it until the register frees. Reset
// clears the calibration registers, the oversampling setting and the stored
// temperature term with its valid flag.
module barometric_pressure_compensation
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [18:0] raw_value, rest zero
	input  logic        s_axis_tuser,  // [0] mode
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] result_value
	output logic [2:0]  m_axis_tuser   // [0] result_kind, [2:1] error_code
);

	// ---------------- configuration ----------------
	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CAL_A: cal_a_q <= pwdata;
				REG_CAL_B: cal_b_q <= pwdata;
				REG_CAL_C: cal_c_q <= pwdata[31:0];
				REG_OSS:   oss_q   <= pwdata[1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAL_A: prdata = cal_a_q;
			REG_CAL_B: prdata = cal_b_q;
			REG_CAL_C: prdata = {32'd0, cal_c_q};
			REG_OSS:   prdata = {62'd0, oss_q};
			default:   prdata = '0;
		endcase
	end

	// calibration words
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic        [15:0] ac4, ac5, ac6;

	assign ac1 = cal_a_q[15:0];
	assign ac2 = cal_a_q[31:16];
	assign ac3 = cal_a_q[47:32];
	assign ac4 = cal_a_q[63:48];
	assign ac5 = cal_b_q[15:0];
	assign ac6 = cal_b_q[31:16];
	assign b1  = cal_b_q[47:32];
	assign b2  = cal_b_q[63:48];
	assign mc  = cal_c_q[15:0];
	assign md  = cal_c_q[31:16];

	// ---------------- datapath registers ----------------
	state_t state_q, state_d;

	logic [18:0]       raw_q;
	logic signed [63:0] x1_q, acc_q, b6_q, sq_q, b3_q, x3_q, p_q;
	logic [31:0]       b4_q, b7_q;
	logic              neg_q;
	logic [31:0]       term_q;
	logic              term_valid_q;
	logic              res_kind_q;
	logic [31:0]       res_value_q;
	err_t              res_err_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic [2:0]        out_user_q;

	// shared multiplier, product registered
	logic signed [51:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [69:0] prod_q;
	logic signed [63:0] prod_w;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end
	assign prod_w = prod_q[63:0];

	// shared divider
	div_req_t    div_req;
	logic        div_done;
	logic [31:0] div_quo;

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// helper values
	logic signed [63:0] md64, den, mc_sh, quo_s, b5, term_s;
	logic [25:0]        ph;
	logic [31:0]        b7_w, x3p, raw_b3;
	logic               s_acc, out_free;

	assign md64   = {{48{md[15]}}, md};
	assign den    = x1_q + md64;
	assign mc_sh  = {{37{mc[15]}}, mc, 11'd0};
	assign quo_s  = neg_q ? -$signed({32'd0, div_quo}) : $signed({32'd0, div_quo});
	assign b5     = x1_q + quo_s;
	assign term_s = {{32{term_q[31]}}, term_q};
	assign ph     = p_q[33:8];
	assign b7_w   = prod_q[31:0];
	assign x3p    = x3_q[31:0] + B4_OFFSET;
	assign raw_b3 = {13'd0, raw_q} - b3_q[31:0];
	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d          = state_q;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		s_axis_tready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == MODE_TEMP)
						state_d = ST_T_MUL;
					else if (!term_valid_q)
						state_d = ST_DONE;
					else
						state_d = ST_P_B6;
				end
			end
			ST_T_MUL: begin
				mul_a   = $signed({33'd0, raw_q}) - $signed({36'd0, ac6});
				mul_b   = $signed({2'd0, ac5});
				state_d = ST_T_X1;
			end
			ST_T_X1: state_d = ST_T_DEN;
			ST_T_DEN: begin
				if (den == 64'sd0) begin
					state_d = ST_DONE;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = mc[15] ? 32'(-mc_sh) : mc_sh[31:0];
					div_req.divisor  = den[63] ? 32'(-den) : den[31:0];
					state_d          = ST_T_DIV;
				end
			end
			ST_T_DIV: if (div_done) state_d = ST_DONE;
			ST_P_B6:  state_d = ST_P_M_SQH;
			ST_P_M_SQH: begin
				mul_a   = b6_q[51:0];
				mul_b   = b6_q[32:15];
				state_d = ST_P_M_SQL;
			end
			ST_P_M_SQL: begin
				mul_a   = b6_q[51:0];
				mul_b   = $signed({3'd0, b6_q[14:0]});
				state_d = ST_P_SQ;
			end
			ST_P_SQ: state_d = ST_P_M_X1;
			ST_P_M_X1: begin
				mul_a   = sq_q[51:0];
				mul_b   = {{2{b2[15]}}, b2};
				state_d = ST_P_M_X2;
			end
			ST_P_M_X2: begin
				mul_a   = b6_q[51:0];
				mul_b   = {{2{ac2[15]}}, ac2};
				state_d = ST_P_M_X1B;
			end
			ST_P_M_X1B: begin
				mul_a   = b6_q[51:0];
				mul_b   = {{2{ac3[15]}}, ac3};
				state_d = ST_P_M_X2B;
			end
			ST_P_M_X2B: begin
				mul_a   = sq_q[51:0];
				mul_b   = {{2{b1[15]}}, b1};
				state_d = ST_P_X3;
			end
			ST_P_X3: state_d = ST_P_M_B4;
			ST_P_M_B4: begin
				mul_a   = $signed({20'd0, x3p});
				mul_b   = $signed({2'd0, ac4});
				state_d = ST_P_M_B7;
			end
			ST_P_M_B7: begin
				mul_a   = $signed({20'd0, raw_b3});
				mul_b   = $signed({2'd0, 16'(B7_SCALE >> oss_q)});
				state_d = ST_P_B7;
			end
			ST_P_B7: begin
				if (b4_q == 32'd0) begin
					state_d = ST_DONE;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = b7_w[31] ? b7_w : {b7_w[30:0], 1'b0};
					div_req.divisor  = b4_q;
					state_d          = ST_P_DIV;
				end
			end
			ST_P_DIV: if (div_done) state_d = ST_P_M_PH;
			ST_P_M_PH: begin
				mul_a   = $signed({26'd0, ph});
				mul_b   = $signed({7'd0, ph[25:15]});
				state_d = ST_P_M_PL;
			end
			ST_P_M_PL: begin
				mul_a   = $signed({26'd0, ph});
				mul_b   = $signed({3'd0, ph[14:0]});
				state_d = ST_P_PSQ;
			end
			ST_P_PSQ: state_d = ST_P_M_C1;
			ST_P_M_C1: begin
				mul_a   = acc_q[51:0];
				mul_b   = P_COEF_SQ;
				state_d = ST_P_M_C2;
			end
			ST_P_M_C2: begin
				mul_a   = p_q[51:0];
				mul_b   = P_COEF_LIN;
				state_d = ST_P_FIN;
			end
			ST_P_FIN: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// stored temperature term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q       <= '0;
			term_valid_q <= 1'b0;
		end else if (state_q == ST_T_DIV && div_done) begin
			term_q       <= b5[31:0];
			term_valid_q <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (s_acc) begin
				raw_q       <= s_axis_tdata[18:0];
				res_kind_q  <= s_axis_tuser;
				res_value_q <= '0;
				res_err_q   <= ERR_NO_TEMP;
			end
			ST_T_X1:  x1_q <= prod_w >>> 15;
			ST_T_DEN: begin
				neg_q       <= mc[15] ^ den[63];
				res_value_q <= '0;
				res_err_q   <= ERR_DIV_ZERO;
			end
			ST_T_DIV: if (div_done) begin
				res_value_q <= 32'((b5 + 64'sd8) >>> 4);
				res_err_q   <= ERR_OK;
			end
			ST_P_B6:    b6_q  <= term_s - B6_OFFSET;
			ST_P_M_SQL: acc_q <= prod_w <<< 15;
			ST_P_SQ:    sq_q  <= (acc_q + prod_w) >>> 12;
			ST_P_M_X2:  acc_q <= ($signed({{48{ac1[15]}}, ac1}) <<< 2) + (prod_w >>> 11);
			ST_P_M_X1B: acc_q <= acc_q + (prod_w >>> 11);
			ST_P_M_X2B: begin
				b3_q <= ((acc_q <<< oss_q) + 64'sd2) >>> 2;
				x1_q <= prod_w >>> 13;
			end
			ST_P_X3:    x3_q <= (x1_q + (prod_w >>> 16) + 64'sd2) >>> 2;
			ST_P_M_B7:  b4_q <= {15'd0, prod_q[31:15]};
			ST_P_B7: begin
				b7_q        <= b7_w;
				res_value_q <= '0;
				res_err_q   <= ERR_DIV_ZERO;
			end
			ST_P_DIV: if (div_done) begin
				p_q <= b7_q[31] ? $signed({31'd0, div_quo, 1'b0}) : $signed({32'd0, div_quo});
			end
			ST_P_M_PL:  acc_q <= prod_w <<< 15;
			ST_P_PSQ:   acc_q <= acc_q + prod_w;
			ST_P_M_C2:  x1_q  <= prod_w >>> 16;
			ST_P_FIN: begin
				res_value_q <= 32'(p_q + ((x1_q + (prod_w >>> 16) + P_OFFSET) >>> 4));
				res_err_q   <= ERR_OK;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= res_value_q;
			out_user_q <= {res_err_q, res_kind_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
	// missing-temperature error only ever comes from a pressure item
	a_no_temp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_err_q == ERR_NO_TEMP) |-> res_kind_q == MODE_PRESS)
		else $error("no-temperature error on a temperature item");

	// once a term is stored it stays valid until reset
	a_term_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(term_valid_q))
		else $error("temperature term valid flag dropped");

	// flagged results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2:1] != ERR_OK) |-> m_axis_tdata == 32'd0)
		else $error("error result with non-zero value");

	// divider is only started from a divide-issue state
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> (state_q == ST_T_DIV || state_q == ST_P_DIV))
		else $error("divider started outside a divide step");
`endif

endmodule

// ----- rtl/core/bpc_div.sv -----
module bpc_div
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        ge;

	// restoring, one quotient bit a cycle; quotient shifts into dvd_q
	assign rem_sh = {rem_q, dvd_q[31]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
			dvd_q <= {dvd_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import bpc_pkg::*;

	// one compensated reading as it leaves the block
	typedef struct {
		mode_t       kind;
		logic [31:0] value;
		err_t        err;
	} reading_t;

	// directed stimulus row; typed rows carry their expected reading
	typedef struct {
		int          phase;
		mode_t       kind;
		logic [18:0] raw;
		bit          typed;
		logic [31:0] value;
		err_t        err;
	} row_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_GAP   = 60;   // longer than the pressure latency

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [18:0] raw_value, rest zero
	logic        s_axis_tuser;   // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] result_value
	logic [2:0]  m_axis_tuser;   // [0] result_kind, [2:1] error_code

	// predictor's own copy of the registers and the stored temperature term
	logic [63:0] cal_a;
	logic [63:0] cal_b;
	logic [31:0] cal_c;
	logic [1:0]  oss_set;
	logic [31:0] term_b5;
	bit          term_ok;

	reading_t    pending_readings[$];
	int          fail_cnt;
	int          cycle_cnt;
	bit          gaps_on;        // random idling on both sides
	bit          long_hold_req;  // receiver to hold off for a long stretch

	barometric_pressure_compensation u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic longint s16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint u16(input logic [15:0] v);
		return longint'({48'd0, v});
	endfunction

	// integer compensation scheme; updates the stored term on a good temperature beat
	function automatic void compensate(input mode_t kind, input logic [18:0] raw,
			output reading_t o);
		longint r, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		longint x1, x2, x3, den, b3, b5, b6, sq, p;
		logic [31:0] t32, b4, b7;
		o.kind  = kind;
		o.value = '0;
		o.err   = ERR_OK;
		r = longint'({45'd0, raw});
		if (kind == MODE_TEMP) begin
			ac5 = u16(cal_b[15:0]);
			ac6 = u16(cal_b[31:16]);
			mc  = s16(cal_c[15:0]);
			md  = s16(cal_c[31:16]);
			x1  = ((r - ac6) * ac5) >>> 15;
			den = x1 + md;
			if (den == 0) begin
				o.err = ERR_DIV_ZERO;   // state left as it was
			end else begin
				b5 = x1 + (mc * 2048) / den;   // truncates toward zero
				term_b5 = b5[31:0];
				term_ok = 1'b1;
				p = (b5 + 8) >>> 4;
				o.value = p[31:0];
			end
		end else if (!term_ok) begin
			o.err = ERR_NO_TEMP;
		end else begin
			ac1 = s16(cal_a[15:0]);
			ac2 = s16(cal_a[31:16]);
			ac3 = s16(cal_a[47:32]);
			b1  = s16(cal_b[47:32]);
			b2  = s16(cal_b[63:48]);
			b5  = longint'($signed(term_b5));
			b6  = b5 - 4000;
			sq  = (b6 * b6) >>> 12;   // squared term shifted before the b2 product
			x1  = (b2 * sq) >>> 11;
			x2  = (ac2 * b6) >>> 11;
			b3  = (((ac1 * 4 + x1 + x2) <<< oss_set) + 2) >>> 2;
			x1  = (ac3 * b6) >>> 13;
			x2  = (b1 * sq) >>> 16;
			x3  = (x1 + x2 + 2) >>> 2;
			t32 = 32'(x3 + 32768);
			t32 = cal_a[63:48] * t32;   // wraps to 32 bits
			b4  = t32 >> 15;
			t32 = 32'(r - b3);
			b7  = t32 * (32'd50000 >> oss_set);
			if (b4 == 0) begin
				o.err = ERR_DIV_ZERO;
			end else begin
				if (!b7[31])
					p = longint'({31'd0, b7, 1'b0}) / longint'(b4);
				else
					p = longint'(b7 / b4) * 2;
				x1 = (p >>> 8) * (p >>> 8);
				x1 = (x1 * 3038) >>> 16;
				x2 = (-7357 * p) >>> 16;
				p  = p + ((x1 + x2 + 3791) >>> 4);
				o.value = p[31:0];
			end
		end
	endfunction

	// APB write: setup beat then access beat; pready is always high
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_CAL_A: cal_a   = v;
			REG_CAL_B: cal_b   = v;
			REG_CAL_C: cal_c   = v[31:0];
			REG_OSS:   oss_set = v[1:0];
		endcase
	endtask

	task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
			input logic [31:0] c, input logic [1:0] o);
		reg_write(REG_CAL_A, a);
		reg_write(REG_CAL_B, b);
		reg_write(REG_CAL_C, {32'd0, c});
		reg_write(REG_OSS, {62'd0, o});
	endtask

	// sender pauses until every reading is back, plus the block's latency
	task automatic drain();
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// offer one beat; tvalid stays high across back-to-back beats
	task automatic send_beat(input mode_t kind, input logic [18:0] raw,
			input bit typed, input reading_t typed_exp);
		reading_t exp_r;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {5'd0, raw};
		do
			@(posedge clk);
		while (!s_axis_tready);
		compensate(kind, raw, exp_r);
		pending_readings.push_back(typed ? typed_exp : exp_r);
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: check each result beat, then pick next tready
	int stall_left;
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_readings.size() == 0) begin
				$error("result beat with no reading expected: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				fail_cnt++;
			end else begin
				want = pending_readings.pop_front();
				if (m_axis_tuser[0] !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser[0]);
					fail_cnt++;
				end
				if (m_axis_tdata !== want.value) begin
					$error("result_value: expected %0d, got %0d",
						$signed(want.value), $signed(m_axis_tdata));
					fail_cnt++;
				end
				if (m_axis_tuser[2:1] !== want.err) begin
					$error("error_code: expected %0d, got %0d", want.err, m_axis_tuser[2:1]);
					fail_cnt++;
				end
			end
		end
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = 400;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// directed rows; phase 0 runs on reset values, phase 1 on a typical
	// calibration, phase 2 keeps a term while the temperature divisor is zero,
	// phase 3 has ac4 zero so the pressure divisor is zero
	row_t rows[] = '{
		'{0, MODE_PRESS, 19'd0,       1, 32'd0, ERR_NO_TEMP},
		'{0, MODE_PRESS, 19'h7FFFF,   1, 32'd0, ERR_NO_TEMP},
		'{0, MODE_TEMP,  19'd0,       1, 32'd0, ERR_DIV_ZERO},
		'{0, MODE_TEMP,  19'h7FFFF,   1, 32'd0, ERR_DIV_ZERO},
		'{0, MODE_PRESS, 19'd23843,   1, 32'd0, ERR_NO_TEMP},
		'{1, MODE_PRESS, 19'd1000,    1, 32'd0, ERR_NO_TEMP},
		'{1, MODE_TEMP,  19'd27898,   0, 32'd0, ERR_OK},
		'{1, MODE_PRESS, 19'd23843,   0, 32'd0, ERR_OK},
		'{1, MODE_PRESS, 19'd0,       0, 32'd0, ERR_OK},
		'{1, MODE_PRESS, 19'h7FFFF,   0, 32'd0, ERR_OK},
		'{1, MODE_TEMP,  19'd0,       0, 32'd0, ERR_OK},
		'{1, MODE_PRESS, 19'd65535,   0, 32'd0, ERR_OK},
		'{1, MODE_TEMP,  19'h7FFFF,   0, 32'd0, ERR_OK},
		'{1, MODE_PRESS, 19'h55555,   0, 32'd0, ERR_OK},
		'{1, MODE_TEMP,  19'd65535,   0, 32'd0, ERR_OK},
		'{1, MODE_PRESS, 19'h2AAAA,   0, 32'd0, ERR_OK},
		'{2, MODE_TEMP,  19'd27898,   1, 32'd0, ERR_DIV_ZERO},
		'{2, MODE_PRESS, 19'd23843,   0, 32'd0, ERR_OK},
		'{2, MODE_TEMP,  19'h7FFFF,   1, 32'd0, ERR_DIV_ZERO},
		'{2, MODE_PRESS, 19'h40000,   0, 32'd0, ERR_OK},
		'{3, MODE_PRESS, 19'd23843,   1, 32'd0, ERR_DIV_ZERO},
		'{3, MODE_TEMP,  19'd30000,   0, 32'd0, ERR_OK},
		'{3, MODE_PRESS, 19'd0,       1, 32'd0, ERR_DIV_ZERO}
	};

	// typical factory words: ac1 408, ac2 -72, ac3 -14383, ac4 32741,
	// ac5 32757, ac6 23153, b1 6190, b2 4, mc -8711, md 2868
	localparam logic [63:0] TYP_A = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
	localparam logic [63:0] TYP_B = {16'd4, 16'd6190, 16'd23153, 16'd32757};
	localparam logic [31:0] TYP_C = {16'd2868, 16'hDDF9};

	task automatic set_phase(input int ph);
		case (ph)
			1: load_cal(TYP_A, TYP_B, TYP_C, 2'd0);
			2: load_cal(TYP_A, {TYP_B[63:16], 16'd0}, {16'd0, TYP_C[15:0]}, 2'd3);
			3: load_cal({16'd0, TYP_A[47:0]}, TYP_B, TYP_C, 2'd1);
			default: ;
		endcase
	endtask

	// calibration for a random phase: typical words nudged, or wholly random,
	// or the all-ones extreme
	task automatic random_cal(input int ph);
		logic [63:0] a, b;
		logic [31:0] c;
		case ($urandom_range(0, 5))
			0: begin
				a = {$urandom, $urandom};
				b = {$urandom, $urandom};
				c = $urandom;
			end
			1: begin
				a = '1;
				b = '1;
				c = '1;
			end
			default: begin
				a = TYP_A ^ {4{6'd0, 10'($urandom)}};
				b = TYP_B ^ {4{6'd0, 10'($urandom)}};
				c = TYP_C ^ {2{6'd0, 10'($urandom)}};
			end
		endcase
		load_cal(a, b, c, 2'(ph));
	endtask

	function automatic logic [18:0] pick_raw(input mode_t kind);
		if ($urandom_range(0, 9) == 0)
			return 19'($urandom);
		if (kind == MODE_TEMP)
			return 19'($urandom_range(0, 65535));
		return 19'($urandom_range(0, (65536 << oss_set) - 1));
	endfunction

	initial begin
		reading_t typed_exp;
		reading_t none;
		mode_t    kind;
		int       cur_phase;
		int       pick;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = MODE_TEMP;
		m_axis_tready = 1'b0;
		cal_a         = '0;
		cal_b         = '0;
		cal_c         = '0;
		oss_set       = '0;
		term_b5       = '0;
		term_ok       = 1'b0;
		fail_cnt      = 0;
		cycle_cnt     = 0;
		stall_left    = 0;
		gaps_on       = 1'b1;
		long_hold_req = 1'b0;
		none          = '{MODE_TEMP, 32'd0, ERR_OK};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part; config changes only between phases, once drained
		cur_phase = 0;
		foreach (rows[i]) begin
			if (rows[i].phase != cur_phase) begin
				end_burst();
				drain();
				cur_phase = rows[i].phase;
				set_phase(cur_phase);
			end
			typed_exp = '{rows[i].kind, rows[i].value, rows[i].err};
			send_beat(rows[i].kind, rows[i].raw, rows[i].typed, typed_exp);
		end
		end_burst();
		drain();

		// random part: about three in ten beats are temperature, six in ten pressure,
		// the rest a random kind; the last phase runs without idling
		for (int ph = 0; ph < 11; ph++) begin
			random_cal(ph);
			if (ph == 10)
				gaps_on = 1'b0;
			if (ph == 5)
				long_hold_req = 1'b1;   // block fills and stalls its input
			for (int n = 0; n < 148; n++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					kind = mode_t'($urandom_range(0, 1));
				else if (pick <= 3)
					kind = MODE_TEMP;
				else
					kind = MODE_PRESS;
				send_beat(kind, pick_raw(kind), 1'b0, none);
			end
			end_burst();
			drain();
		end

		if (fail_cnt == 0 && pending_readings.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
